// ----- rtl/timed_wait_queue_defines.svh -----
// Assertion macros used by the timed wait queue top level.
`ifndef TIMED_WAIT_QUEUE_DEFINES_SVH
`define TIMED_WAIT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TWQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TWQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/twq_pkg.sv -----
// Package: types, codes and defaults of the timed wait queue.
`default_nettype none
package twq_pkg;

  localparam int unsigned TWQ_DEPTH_DEFAULT = 16;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_REL  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_REL
  } twq_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_TICK,
    OP_FLUSH,
    OP_REL
  } twq_op_t;

  typedef struct packed {
    twq_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic idx_zero;
    logic res_free;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] id;
    logic       id_valid;
    logic       timed_out;
    logic [1:0] status;
    logic [4:0] occupancy;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/timed_wait_queue.sv -----
// Top level of the timed wait queue: controller, datapath and checks.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   command  | cmd_valid / cmd_ready | command, thread_id, wait_ticks, limited
//   result   | res_valid / res_ready | out_thread_id, id_valid, timed_out,
//            |                       | status, occupancy, last
//
// Put and get load their result into the output register as they are accepted.
// Tick walks the held entries, one slot read per cycle through the slot read
// mux while the result register is free, then a flush marks the final result.
// Release returns entries newest first; an empty queue answers on acceptance.
// Reset clears the entry count, controller state and output valid; slot
// contents stay unset. A full output register stalls the walk in place.
`default_nettype none
`include "timed_wait_queue_defines.svh"
module timed_wait_queue import twq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = TWQ_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  thread_id,
  input  logic [15:0] wait_ticks,
  input  logic        limited,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_thread_id,
  output logic        id_valid,
  output logic        timed_out,
  output logic [1:0]  status,
  output logic [4:0]  occupancy,
  output logic        last
);

  dp_cmd_t    ctrl;
  dp_status_t stat;
  res_t       res;

  twq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  twq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .command    (command),
    .thread_id  (thread_id),
    .wait_ticks (wait_ticks),
    .limited    (limited),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_thread_id = res.id;
  assign id_valid      = res.id_valid;
  assign timed_out     = res.timed_out;
  assign status        = res.status;
  assign occupancy     = res.occupancy;
  assign last          = res.last;

  `TWQ_ASSERT_IMP(a_ready_needs_room, clk, rst, cmd_valid && cmd_ready, !res_valid || res_ready, "command taken while result register blocked")
  `TWQ_ASSERT_NXT(a_single_result, clk, rst, cmd_valid && cmd_ready && (command == CMD_PUT || command == CMD_GET), res_valid && last, "put or get gave no final result")
  `TWQ_ASSERT_IMP(a_timeout_has_id, clk, rst, res_valid && timed_out, id_valid && status == ST_OK, "timeout result without thread id")

endmodule
`default_nettype wire

// ----- rtl/twq_controller.sv -----
// Controller: sequences command intake, tick walk, flush and release.
`default_nettype none
module twq_controller import twq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] command,
  input  dp_status_t stat,
  output dp_cmd_t    ctrl
);

  twq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && stat.res_free && !stat.count_zero) begin
          if (command == CMD_TICK) begin
            state_next = S_WALK;
          end else if (command == CMD_REL) begin
            state_next = S_REL;
          end
        end
      end
      S_WALK: begin
        if (stat.res_free && stat.idx_zero) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.res_free) begin
          state_next = S_IDLE;
        end
      end
      S_REL: begin
        if (stat.res_free && stat.count_one) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    ctrl.op   = OP_NONE;
    case (state)
      S_IDLE: begin
        cmd_ready = stat.res_free;
        if (cmd_valid && stat.res_free) begin
          ctrl.op = OP_ACCEPT;
        end
      end
      S_WALK: begin
        if (stat.res_free) begin
          ctrl.op = OP_TICK;
        end
      end
      S_FLUSH: begin
        if (stat.res_free) begin
          ctrl.op = OP_FLUSH;
        end
      end
      S_REL: begin
        if (stat.res_free) begin
          ctrl.op = OP_REL;
        end
      end
      default: ctrl.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/twq_datapath.sv -----
// Datapath: slot registers, entry count, walk index, held and output results.
`default_nettype none
module twq_datapath import twq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = TWQ_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     ctrl,
  output dp_status_t  stat,
  input  logic [1:0]  command,
  input  logic [7:0]  thread_id,
  input  logic [15:0] wait_ticks,
  input  logic        limited,
  input  logic        res_ready,
  output logic        res_valid,
  output res_t        res
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]       slot_thread    [QUEUE_DEPTH];
  logic [15:0]      slot_remaining [QUEUE_DEPTH];
  logic             slot_is_limited[QUEUE_DEPTH];
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             pend_valid, pend_valid_next;
  res_t             pend, pend_next;

  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] top_idx, put_idx, sel;
  logic [7:0]       rd_thread;
  logic [15:0]      rd_rem, rem_dec;
  logic             rd_lim, expired, full;
  logic             shift_en, put_en, dec_en, load;
  res_t             res_new;

  assign count_m1 = count - CNT_W'(1);
  assign top_idx  = count_m1[IDX_W-1:0];
  assign put_idx  = count[IDX_W-1:0];
  assign full     = (count == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    case (ctrl.op)
      OP_TICK: sel = idx;
      OP_REL:  sel = top_idx;
      default: sel = '0;
    endcase
  end

  assign rd_thread = slot_thread[sel];
  assign rd_rem    = slot_remaining[sel];
  assign rd_lim    = slot_is_limited[sel];
  assign rem_dec   = rd_rem - 16'd1;
  assign expired   = rd_lim && (rem_dec == 16'd0);

  always_comb begin
    shift_en        = 1'b0;
    put_en          = 1'b0;
    dec_en          = 1'b0;
    load            = 1'b0;
    count_next      = count;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    res_new         = '0;
    case (ctrl.op)
      OP_ACCEPT: begin
        case (command)
          CMD_PUT: begin
            load         = 1'b1;
            res_new.last = 1'b1;
            if (full) begin
              res_new.status    = ST_FULL;
              res_new.occupancy = 5'(count);
            end else begin
              put_en            = 1'b1;
              count_next        = count + CNT_W'(1);
              res_new.occupancy = 5'(count + CNT_W'(1));
            end
          end
          CMD_GET: begin
            load         = 1'b1;
            res_new.last = 1'b1;
            if (count == '0) begin
              res_new.status = ST_EMPTY;
            end else begin
              shift_en          = 1'b1;
              count_next        = count_m1;
              res_new.id        = rd_thread;
              res_new.id_valid  = 1'b1;
              res_new.occupancy = 5'(count_m1);
            end
          end
          CMD_TICK: begin
            if (count == '0) begin
              load         = 1'b1;
              res_new.last = 1'b1;
            end else begin
              idx_next        = top_idx;
              pend_valid_next = 1'b0;
            end
          end
          default: begin
            if (count == '0) begin
              load         = 1'b1;
              res_new.last = 1'b1;
            end
          end
        endcase
      end
      OP_TICK: begin
        idx_next = idx - IDX_W'(1);
        if (expired) begin
          // expired entry is held back until the next expiry or the flush so the final one can carry last
          shift_en            = 1'b1;
          count_next          = count_m1;
          pend_valid_next     = 1'b1;
          pend_next           = '0;
          pend_next.id        = rd_thread;
          pend_next.id_valid  = 1'b1;
          pend_next.timed_out = 1'b1;
          pend_next.occupancy = 5'(count_m1);
          if (pend_valid) begin
            load    = 1'b1;
            res_new = pend;
          end
        end else if (rd_lim) begin
          dec_en = 1'b1;
        end
      end
      OP_FLUSH: begin
        load            = 1'b1;
        pend_valid_next = 1'b0;
        if (pend_valid) begin
          res_new = pend;
        end else begin
          res_new.occupancy = 5'(count);
        end
        res_new.last = 1'b1;
      end
      OP_REL: begin
        load              = 1'b1;
        count_next        = count_m1;
        res_new.id        = rd_thread;
        res_new.id_valid  = 1'b1;
        res_new.occupancy = 5'(count_m1);
        res_new.last      = (count == CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (put_en && (IDX_W'(j) == put_idx)) begin
        slot_thread[j]     <= thread_id;
        slot_remaining[j]  <= wait_ticks;
        slot_is_limited[j] <= limited;
      end else if (dec_en && (IDX_W'(j) == sel)) begin
        slot_remaining[j] <= rem_dec;
      end
    end
    // on removal, each slot from the removed one up to the next-to-top takes its upper neighbor
    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
      if (shift_en && (IDX_W'(j) >= sel)) begin
        slot_thread[j]     <= slot_thread[j+1];
        slot_remaining[j]  <= slot_remaining[j+1];
        slot_is_limited[j] <= slot_is_limited[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      pend_valid <= pend_valid_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pend <= pend_next;
    if (load) begin
      res <= res_new;
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.count_one  = (count == CNT_W'(1));
  assign stat.idx_zero   = (idx == '0);
  assign stat.res_free   = !res_valid || res_ready;

endmodule
`default_nettype wire

// ----- sim/timed_wait_queue_tb.sv -----
// Testbench for timed_wait_queue: directed and random commands checked against a queue model.
`timescale 1ns / 100ps

module timed_wait_queue_tb import twq_pkg::*; ();

  localparam int unsigned DEPTH = TWQ_DEPTH_DEFAULT;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [1:0]  command;
  logic [7:0]  thread_id;
  logic [15:0] wait_ticks;
  logic        limited;
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  out_thread_id;
  logic        id_valid;
  logic        timed_out;
  logic [1:0]  status;
  logic [4:0]  occupancy;
  logic        last;

  bit idle_on = 1'b1;

  timed_wait_queue DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .command(command),
    .thread_id(thread_id),
    .wait_ticks(wait_ticks),
    .limited(limited),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_thread_id(out_thread_id),
    .id_valid(id_valid),
    .timed_out(timed_out),
    .status(status),
    .occupancy(occupancy),
    .last(last)
  );

  class wait_queue_scoreboard;
    logic [7:0]  slot_id [DEPTH];
    logic [15:0] slot_left [DEPTH];
    logic        slot_lim [DEPTH];
    int unsigned held;
    int unsigned errors;
    res_t        expected_results [$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void add_result(logic [7:0] id, logic v, logic to, logic [1:0] st);
      res_t r;
      r.id = id;
      r.id_valid = v;
      r.timed_out = to;
      r.status = st;
      r.occupancy = held[4:0];
      r.last = 1'b0;
      expected_results.push_back(r);
    endfunction

    // close the gap left by a removed entry
    function void drop_slot(int unsigned idx);
      int unsigned j;
      for (j = idx; j + 1 < held; j++) begin
        slot_id[j] = slot_id[j + 1];
        slot_left[j] = slot_left[j + 1];
        slot_lim[j] = slot_lim[j + 1];
      end
      held--;
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] tid, logic [15:0] wt, logic lim);
      int          first;
      int          i;
      logic [7:0]  id;
      res_t        r;
      first = expected_results.size();
      case (cmd)
        CMD_PUT: begin
          if (held >= DEPTH) begin
            add_result(8'd0, 1'b0, 1'b0, ST_FULL);
          end else begin
            slot_id[held] = tid;
            slot_left[held] = wt;
            slot_lim[held] = lim;
            held++;
            add_result(8'd0, 1'b0, 1'b0, ST_OK);
          end
        end
        CMD_GET: begin
          if (held == 0) begin
            add_result(8'd0, 1'b0, 1'b0, ST_EMPTY);
          end else begin
            id = slot_id[0];
            drop_slot(0);
            add_result(id, 1'b1, 1'b0, ST_OK);
          end
        end
        CMD_TICK: begin
          // newest to oldest; a zero count wraps to 65535
          for (i = int'(held) - 1; i >= 0; i--) begin
            if (slot_lim[i]) begin
              slot_left[i] = slot_left[i] - 16'd1;
              if (slot_left[i] == 16'd0) begin
                id = slot_id[i];
                drop_slot(i);
                add_result(id, 1'b1, 1'b1, ST_OK);
              end
            end
          end
          if (expected_results.size() == first) add_result(8'd0, 1'b0, 1'b0, ST_OK);
        end
        default: begin
          while (held > 0) begin
            held--;
            add_result(slot_id[held], 1'b1, 1'b0, ST_OK);
          end
          if (expected_results.size() == first) add_result(8'd0, 1'b0, 1'b0, ST_OK);
        end
      endcase
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] id, logic v, logic to, logic [1:0] st,
                               logic [4:0] occ, logic lst);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: out_thread_id %0d", id);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (id !== e.id) begin
        $error("out_thread_id: expected %0d, got %0d", e.id, id);
        errors++;
      end
      if (v !== e.id_valid) begin
        $error("id_valid: expected %0d, got %0d", e.id_valid, v);
        errors++;
      end
      if (to !== e.timed_out) begin
        $error("timed_out: expected %0d, got %0d", e.timed_out, to);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (occ !== e.occupancy) begin
        $error("occupancy: expected %0d, got %0d", e.occupancy, occ);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  wait_queue_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timed_wait_queue test failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result(out_thread_id, id_valid, timed_out, status, occupancy, last);
  end

  task automatic send_cmd(logic [1:0] cmd, logic [7:0] tid, logic [15:0] wt, logic lim);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    thread_id <= tid;
    wait_ticks <= wt;
    limited <= lim;
    do @(posedge clk); while (!cmd_ready);
    sb.note_command(cmd, tid, wt, lim);
  endtask

  function automatic logic [15:0] pick_wait();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd0;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic put_random();
    send_cmd(CMD_PUT, 8'($urandom_range(0, 255)), pick_wait(), $urandom_range(0, 3) != 0);
  endtask

  initial begin
    int k;
    int n;
    int sel;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    command <= CMD_PUT;
    thread_id <= 8'd0;
    wait_ticks <= 16'd0;
    limited <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue answers
    send_cmd(CMD_GET, 8'd0, 16'd0, 1'b0);
    send_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0);
    send_cmd(CMD_REL, 8'd0, 16'd0, 1'b0);
    // field extremes; the zero-wait entry wraps instead of expiring
    send_cmd(CMD_PUT, 8'd0, 16'hFFFF, 1'b1);
    send_cmd(CMD_PUT, 8'd255, 16'h0000, 1'b1);
    send_cmd(CMD_PUT, 8'hA5, 16'd1, 1'b1);
    send_cmd(CMD_PUT, 8'h5A, 16'd2, 1'b0);
    send_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0);
    send_cmd(CMD_GET, 8'd0, 16'd0, 1'b0);
    // fill to the top, overflow, then several expire in one tick
    for (k = 0; k < 14; k++) send_cmd(CMD_PUT, 8'(16 + k), 16'd1, k[0]);
    send_cmd(CMD_PUT, 8'h77, 16'h1234, 1'b1);
    send_cmd(CMD_TICK, 8'd0, 16'd0, 1'b0);
    send_cmd(CMD_REL, 8'd0, 16'd0, 1'b0);

    k = 0;
    while (k < 100) begin
      if (k >= 80) idle_on = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(4, 18);
        repeat (n) put_random();
        k += n;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) put_random();
        else if (sel < 65) send_cmd(CMD_GET, 8'($urandom_range(0, 255)), 16'($urandom), 1'($urandom));
        else if (sel < 92) send_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom), 1'($urandom));
        else send_cmd(CMD_REL, 8'($urandom_range(0, 255)), 16'($urandom), 1'($urandom));
        k++;
      end
    end
    cmd_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("timed_wait_queue test passed");
    end else begin
      $display("timed_wait_queue test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/twq_pkg.sv
rtl/twq_controller.sv
rtl/twq_datapath.sv
rtl/timed_wait_queue.sv
sim/timed_wait_queue_tb.sv
